// ===== hw/rtl/chte_pkg.sv =====
package chte_pkg;

    // default sizes of the table
    localparam int NUM_BUCKETS_DEF  = 10;
    localparam int BUCKET_DEPTH_DEF = 8;

    // beat field widths
    localparam int ACT_W  = 2;
    localparam int KEY_W  = 16;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int BKT_W  = 6;
    localparam int FILL_W = 4;

    // hash divisor and its fixed-point reciprocal (exact for 16-bit keys)
    localparam int HASH_DIVISOR = 10;
    localparam int HASH_SHIFT   = 19;
    localparam int HASH_RECIP   = (2 ** HASH_SHIFT + HASH_DIVISOR - 1) / HASH_DIVISOR;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

endpackage

// ===== hw/rtl/chte_ram.sv =====
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/chte_hash.sv =====
module chte_hash #(
    parameter int NUM_BUCKETS = chte_pkg::NUM_BUCKETS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [chte_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [chte_pkg::BKT_W-1:0] bucket
);

    import chte_pkg::*;

    localparam int QW        = 16;
    localparam int PW        = KEY_W + 16;
    // reciprocal of the bucket count, exact while quotient times rounding error stays
    // below 2^MOD_SHIFT (quotient under 2^16, error under 2^7)
    localparam int MOD_SHIFT = QW + BKT_W + 1;
    localparam int MW        = MOD_SHIFT + 1;
    localparam int PW2       = QW + MW;
    localparam logic [MW-1:0] MOD_RECIP =
        MW'((2 ** MOD_SHIFT + NUM_BUCKETS - 1) / NUM_BUCKETS);
    localparam logic [QW-1:0] NB_C = QW'(NUM_BUCKETS);

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_MUL  = 4'b0010,
        H_QUO  = 4'b0100,
        H_MOD  = 4'b1000
    } hstate_t;

    hstate_t        state_reg, state_next;
    logic [PW-1:0]  prod_reg;
    logic [QW-1:0]  quo_reg;
    logic [PW2-1:0] mprod_reg;
    logic [BKT_W-1:0] rem_reg;
    logic           done_reg, done_next;
    logic [QW-1:0]  quo_div, rem_full;

    // quotient by the bucket count and the remainder left over
    always_comb
    begin
        quo_div  = QW'(mprod_reg >> MOD_SHIFT);
        rem_full = quo_reg - quo_div * NB_C;
    end

    // sequencer: divide by ten, then reduce modulo the bucket count
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                state_next = H_QUO;
            end
            H_QUO:
            begin
                state_next = H_MOD;
            end
            H_MOD:
            begin
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == H_IDLE))
        begin
            prod_reg <= PW'(key) * PW'(HASH_RECIP);
        end
        if (state_reg == H_MUL)
        begin
            quo_reg <= QW'(prod_reg >> HASH_SHIFT);
        end
        if (state_reg == H_QUO)
        begin
            mprod_reg <= PW2'(quo_reg) * PW2'(MOD_RECIP);
        end
        if (state_reg == H_MOD)
        begin
            rem_reg <= rem_full[BKT_W-1:0];
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

// ===== hw/rtl/chained_hash_table_engine.sv =====
// a search walks the bucket slot by slot; a delete that hits also shifts the later entries down one place
// one operation at a time; busy rises once the start beat is taken and is low again in the done beat
// the bucket walk reads one slot of the single-port-read slot memory per cycle
// reset: async active low; all buckets read as empty, slot memory contents are not cleared
// done pulses for one cycle with the result; the receiver cannot stall
module chained_hash_table_engine #(
    parameter int NUM_BUCKETS  = chte_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chte_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [chte_pkg::ACT_W-1:0]  action,
    input  logic [chte_pkg::KEY_W-1:0]  entry_key,
    input  logic [chte_pkg::DATA_W-1:0] entry_data,
    output logic                        done,
    output logic [chte_pkg::STAT_W-1:0] status,
    output logic [chte_pkg::DATA_W-1:0] found_data,
    output logic [chte_pkg::BKT_W-1:0]  bucket_index
);

    import chte_pkg::*;

    localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW    = KEY_W + DATA_W;
    localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(BUCKET_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_FILL  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_SHIFT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [BKT_W-1:0]    bucket_reg, bucket_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]   found_reg, found_next;
    logic                done_reg, done_next;
    logic [NUM_BUCKETS-1:0] fill_vld_reg;

    logic                hash_start, hash_done;
    logic [BKT_W-1:0]    hash_bucket;

    logic                slot_we;
    logic [AW-1:0]       slot_waddr, slot_raddr;
    logic [SW-1:0]       slot_wdata, slot_rdata;
    logic [FILL_W-1:0]   rd_idx, wr_idx;

    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata, fill_rdata, fill_cur;

    logic                hit, last, more;

    // bucket hash unit
    chte_hash #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (entry_key),
        .done  (hash_done),
        .bucket(hash_bucket)
    );

    // key and payload slots
    chte_ram #(
        .WIDTH(SW),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr(slot_raddr),
        .rdata(slot_rdata)
    );

    // per-bucket fill counts
    chte_ram #(
        .WIDTH(FILL_W),
        .DEPTH(NUM_BUCKETS)
    ) u_fill_ram (
        .clk  (clk),
        .we   (fill_we),
        .waddr(bucket_reg[BW-1:0]),
        .wdata(fill_wdata),
        .raddr(hash_bucket[BW-1:0]),
        .rdata(fill_rdata)
    );

    // walk status of the current slot
    assign fill_cur   = fill_vld_reg[bucket_reg[BW-1:0]] ? fill_rdata : '0;
    assign hit        = (slot_rdata[SW-1:DATA_W] == key_reg);
    assign last       = ({1'b0, idx_reg} + 5'd1) >= {1'b0, fill_reg};
    assign more       = ({1'b0, idx_reg} + 5'd2) < {1'b0, fill_reg};
    assign slot_raddr = base_reg + AW'(rd_idx);
    assign slot_waddr = base_reg + AW'(wr_idx);

    // operation sequencer
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        data_next   = data_reg;
        bucket_next = bucket_reg;
        base_next   = base_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        hash_start  = 1'b0;
        slot_we     = 1'b0;
        slot_wdata  = {key_reg, data_reg};
        wr_idx      = idx_reg;
        rd_idx      = idx_reg;
        fill_we     = 1'b0;
        fill_wdata  = fill_reg - 4'd1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    key_next   = entry_key;
                    data_next  = entry_data;
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    bucket_next = hash_bucket;
                    base_next   = AW'(hash_bucket * BUCKET_DEPTH);
                    state_next  = S_FILL;
                end
            end
            S_FILL:
            begin
                fill_next   = fill_cur;
                idx_next    = '0;
                rd_idx      = '0;
                status_next = ST_MISSING;
                found_next  = '0;
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (fill_cur >= DEPTH_C)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            slot_we     = 1'b1;
                            wr_idx      = fill_cur;
                            fill_we     = 1'b1;
                            fill_wdata  = fill_cur + 4'd1;
                            status_next = ST_OK;
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    ACT_SEARCH, ACT_DELETE:
                    begin
                        if (fill_cur == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // prefetch the next slot unless this is the last one
                rd_idx = last ? idx_reg : idx_reg + 4'd1;
                if (hit)
                begin
                    found_next  = slot_rdata[DATA_W-1:0];
                    status_next = ST_OK;
                    if ((act_reg == ACT_DELETE) && !last)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        fill_we    = (act_reg == ACT_DELETE);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            S_SHIFT:
            begin
                // slot idx+1 is on the read port, move it down one place
                slot_we    = 1'b1;
                slot_wdata = slot_rdata;
                if (more)
                begin
                    rd_idx   = idx_reg + 4'd2;
                    idx_next = idx_reg + 4'd1;
                end
                else
                begin
                    fill_we    = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            fill_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (fill_we)
            begin
                fill_vld_reg[bucket_reg[BW-1:0]] <= 1'b1;
            end
        end
    end

    // operation and result registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        data_reg   <= data_next;
        bucket_reg <= bucket_next;
        base_reg   <= base_next;
        fill_reg   <= fill_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign found_data   = found_reg;
    assign bucket_index = bucket_reg;

`ifndef SYNTHESIS
    // a result only follows an operation in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an operation in flight");

    // no slot is written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !slot_we)
        else $error("slot write while idle");

    // the walk stays inside the filled part of the bucket
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) || (state_reg == S_SHIFT)) |-> (idx_reg < fill_reg))
        else $error("bucket walk beyond fill count");

    // bucket full is only reported for an insert
    a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (act_reg == ACT_INSERT))
        else $error("bucket full status on a non-insert");
`endif

endmodule
